FILE: design/cialu_pkg.sv
// ----------------------------------------------------------------------------
// cialu_pkg
// shared types and constants of the checked integer alu
// ----------------------------------------------------------------------------
`default_nettype none

package cialu_pkg;

  localparam int unsigned ActionW      = 5;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned FieldW       = 64;
  localparam int unsigned DataWidthDef = 64;
  localparam int unsigned InTdataW     = 136;
  localparam int unsigned OutTdataW    = 72;

  typedef enum logic [ActionW-1:0] {
    OP_ADD      = 5'd0,
    OP_SUB      = 5'd1,
    OP_MUL      = 5'd2,
    OP_TDIV     = 5'd3,
    OP_FDIV     = 5'd4,
    OP_MOD      = 5'd5,
    OP_REM      = 5'd6,
    OP_EXACTDIV = 5'd7,
    OP_MIN      = 5'd8,
    OP_MAX      = 5'd9,
    OP_POW      = 5'd10,
    OP_ISOPOW   = 5'd11,
    OP_SHR      = 5'd12,
    OP_SHL      = 5'd13,
    OP_AND      = 5'd14,
    OP_OR       = 5'd15,
    OP_XOR      = 5'd16,
    OP_GCD      = 5'd17,
    OP_NEG      = 5'd18,
    OP_ABS      = 5'd19,
    OP_SIGN     = 5'd20,
    OP_NOT      = 5'd21,
    OP_MSB      = 5'd22,
    OP_SUCC     = 5'd23,
    OP_CMP      = 5'd24
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 3'd0,
    ST_OVF    = 3'd1,
    ST_ZDIV   = 3'd2,
    ST_UNDEF  = 3'd3,
    ST_FLOAT  = 3'd4,
    ST_FTYPE  = 3'd5,
    ST_NOTPOS = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    K_MUL = 2'd0,
    K_DIV = 2'd1,
    K_GCD = 2'd2,
    K_MSB = 2'd3
  } iter_kind_e;

  typedef struct packed {
    logic       start;
    iter_kind_e kind;
  } iter_cmd_t;

endpackage

`default_nettype wire

FILE: design/cialu_iter.sv
// ----------------------------------------------------------------------------
// cialu_iter
// shared iterative unit: shift-add multiply, restoring divide, binary gcd, msb
// ----------------------------------------------------------------------------
`default_nettype none

module cialu_iter import cialu_pkg::*; #(
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire iter_cmd_t            cmd_i,
  input  wire logic [DataWidth-1:0] x_i,
  input  wire logic [DataWidth-1:0] y_i,
  output logic                      done_o,
  output logic [DataWidth-1:0]      hi_o,
  output logic [DataWidth-1:0]      lo_o
);

  localparam int unsigned CntW = $clog2(DataWidth + 1);
  localparam int unsigned KW   = $clog2(DataWidth);
  localparam int unsigned AddW = DataWidth + 2;

  typedef enum logic [4:0] {
    IT_IDLE = 5'b00001,
    IT_MUL  = 5'b00010,
    IT_DIV  = 5'b00100,
    IT_GCD  = 5'b01000,
    IT_MSB  = 5'b10000
  } it_state_e;

  it_state_e            state_q, state_d;
  logic [DataWidth-1:0] hi_q, hi_d, lo_q, lo_d, opnd_q, opnd_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [KW-1:0]        k_q, k_d;
  logic                 done_q, done_d;
  logic [AddW-1:0]      add_a, add_b, sum;
  logic                 add_c;

  assign sum = add_a + add_b + AddW'(add_c);

  always_comb begin
    add_a = '0;
    add_b = '0;
    add_c = 1'b0;
    unique case (state_q)
      IT_MUL: begin
        add_a = AddW'(hi_q);
        add_b = lo_q[0] ? AddW'(opnd_q) : '0;
      end
      IT_DIV: begin
        add_a = AddW'({hi_q, lo_q[DataWidth-1]});
        add_b = ~AddW'(opnd_q);
        add_c = 1'b1;
      end
      IT_GCD: begin
        add_a = AddW'(hi_q);
        add_b = ~AddW'(lo_q);
        add_c = 1'b1;
      end
      IT_MSB: begin
        add_a = AddW'(lo_q);
        add_c = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    opnd_d  = opnd_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    done_d  = 1'b0;
    unique case (state_q)
      IT_IDLE: begin
        if (cmd_i.start) begin
          cnt_d = CntW'(DataWidth);
          k_d   = '0;
          unique case (cmd_i.kind)
            K_MUL: begin
              hi_d = '0; lo_d = y_i; opnd_d = x_i; state_d = IT_MUL;
            end
            K_DIV: begin
              hi_d = '0; lo_d = x_i; opnd_d = y_i; state_d = IT_DIV;
            end
            K_GCD: begin
              hi_d = x_i; lo_d = y_i; state_d = IT_GCD;
            end
            K_MSB: begin
              hi_d = x_i; lo_d = '1; state_d = IT_MSB;
            end
            default: ;
          endcase
        end
      end
      IT_MUL: begin
        hi_d  = sum[DataWidth:1];
        lo_d  = {sum[0], lo_q[DataWidth-1:1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = IT_IDLE;
          done_d  = 1'b1;
        end
      end
      IT_DIV: begin
        if (!sum[AddW-1]) begin
          hi_d = sum[DataWidth-1:0];
          lo_d = {lo_q[DataWidth-2:0], 1'b1};
        end else begin
          hi_d = {hi_q[DataWidth-2:0], lo_q[DataWidth-1]};
          lo_d = {lo_q[DataWidth-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = IT_IDLE;
          done_d  = 1'b1;
        end
      end
      IT_GCD: begin
        priority if (hi_q == '0) begin
          lo_d    = lo_q << k_q;
          state_d = IT_IDLE;
          done_d  = 1'b1;
        end else if (lo_q == '0) begin
          lo_d    = hi_q << k_q;
          state_d = IT_IDLE;
          done_d  = 1'b1;
        end else if (!hi_q[0] && !lo_q[0]) begin
          hi_d = hi_q >> 1;
          lo_d = lo_q >> 1;
          k_d  = k_q + 1'b1;
        end else if (!hi_q[0]) begin
          hi_d = hi_q >> 1;
        end else if (!lo_q[0]) begin
          lo_d = lo_q >> 1;
        end else if (!sum[AddW-1]) begin
          hi_d = sum[DataWidth-1:0] >> 1;
        end else begin
          hi_d = lo_q;
          lo_d = hi_q;
        end
      end
      IT_MSB: begin
        if (hi_q == '0) begin
          state_d = IT_IDLE;
          done_d  = 1'b1;
        end else begin
          hi_d = hi_q >> 1;
          lo_d = sum[DataWidth-1:0];
        end
      end
      default: state_d = IT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IT_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    opnd_q <= opnd_d;
  end

  assign done_o = done_q;
  assign hi_o   = hi_q;
  assign lo_o   = lo_q;

endmodule

`default_nettype wire

FILE: design/cialu_fast.sv
// ----------------------------------------------------------------------------
// cialu_fast
// combinational operations and the early status of the iterative ones
// ----------------------------------------------------------------------------
`default_nettype none

module cialu_fast import cialu_pkg::*; #(
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  wire action_e              op_i,
  input  wire logic [DataWidth-1:0] a_i,
  input  wire logic [DataWidth-1:0] b_i,
  output logic [DataWidth-1:0]      val_o,
  output status_e                   st_o
);

  localparam int unsigned      ShW  = $clog2(DataWidth);
  localparam logic [DataWidth-1:0] MaxV = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic [DataWidth-1:0] MinV = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic [DataWidth-1:0] One  = DataWidth'(1);
  localparam logic [DataWidth-1:0] Wm1  = DataWidth'(DataWidth - 1);

  logic [DataWidth:0]   add_s, sub_s;
  logic                 a_lt_b, sh_bad;
  logic [ShW-1:0]       sh;
  logic [DataWidth-1:0] v;
  status_e              st;

  assign add_s  = {a_i[DataWidth-1], a_i} + {b_i[DataWidth-1], b_i};
  assign sub_s  = {a_i[DataWidth-1], a_i} - {b_i[DataWidth-1], b_i};
  assign a_lt_b = $signed(a_i) < $signed(b_i);
  assign sh_bad = b_i[DataWidth-1] || (b_i > Wm1);
  assign sh     = b_i[ShW-1:0];

  always_comb begin
    v  = '0;
    st = ST_OK;
    unique case (op_i)
      OP_ADD: if (add_s[DataWidth] != add_s[DataWidth-1]) st = ST_OVF;
              else v = add_s[DataWidth-1:0];
      OP_SUB: if (sub_s[DataWidth] != sub_s[DataWidth-1]) st = ST_OVF;
              else v = sub_s[DataWidth-1:0];
      OP_TDIV, OP_FDIV, OP_MOD, OP_REM, OP_EXACTDIV: st = ST_ZDIV;
      OP_MIN: v = a_lt_b ? a_i : b_i;
      OP_MAX: v = a_lt_b ? b_i : a_i;
      OP_POW: st = ST_FLOAT;
      OP_ISOPOW: begin
        priority if (a_i == One)  v = One;
        else if (a_i == '1)       v = b_i[0] ? '1 : One;
        else if (a_i == '0)       st = ST_ZDIV;
        else                      st = ST_FTYPE;
      end
      OP_SHR: if (sh_bad) st = ST_UNDEF;
              else v = DataWidth'($signed(a_i) >>> sh);
      OP_SHL: if (sh_bad) st = ST_UNDEF;
              else v = a_i << sh;
      OP_AND: v = a_i & b_i;
      OP_OR:  v = a_i | b_i;
      OP_XOR: v = a_i ^ b_i;
      OP_NEG: if (a_i == MinV) st = ST_OVF;
              else v = -a_i;
      OP_ABS: if (a_i == MinV) st = ST_OVF;
              else v = a_i[DataWidth-1] ? -a_i : a_i;
      OP_SIGN: v = a_i[DataWidth-1] ? '1 : (a_i == '0) ? '0 : One;
      OP_NOT: v = ~a_i;
      OP_MSB: st = ST_NOTPOS;
      OP_SUCC: if (a_i == MaxV) st = ST_OVF;
               else v = a_i + One;
      OP_CMP: v = a_lt_b ? '1 : (a_i == b_i) ? '0 : One;
      default: st = ST_UNDEF;
    endcase
  end

  assign val_o = (st == ST_OK) ? v : '0;
  assign st_o  = st;

endmodule

`default_nettype wire

FILE: design/checked_integer_alu64_top.sv
// ----------------------------------------------------------------------------
// checked_integer_alu64_top
// checked signed integer alu with one shared iterative unit
// ----------------------------------------------------------------------------
// One request at a time; s_axis_tready is high only while the unit is idle
// and no result waits. Simple operations are latched from the request,
// evaluated by cialu_fast in S_DISP and registered as the result. Multiply,
// divide, gcd and msb run in the shared cialu_iter, and power runs one
// multiply per set exponent bit for the accumulator and one for squaring
// while higher exponent bits remain; with a large exponent, squaring a base
// of magnitude above one soon overflows and ends the power early. The single
// shared adder in cialu_iter retires one bit per cycle in multiply and divide.
`default_nettype none

module checked_integer_alu64_top import cialu_pkg::*; #(
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // action[4:0], operand_a[68:5], operand_b[132:69], zero pad
  input  wire logic [InTdataW-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // result_value[63:0], status[66:64], zero pad
  output logic [OutTdataW-1:0]      m_axis_tdata
);

  localparam logic [DataWidth-1:0] MinV = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic [DataWidth-1:0] One  = DataWidth'(1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DISP   = 7'b0000010,
    S_ITER   = 7'b0000100,
    S_PTEST  = 7'b0001000,
    S_PACC   = 7'b0010000,
    S_PSHIFT = 7'b0100000,
    S_PSQR   = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  action_e              op_q, op_d;
  logic [DataWidth-1:0] a_q, a_d, b_q, b_d;
  logic [DataWidth-1:0] base_q, base_d, acc_q, acc_d, e_q, e_d;
  logic                 mneg_q, mneg_d;
  logic                 out_valid_q, out_valid_d;
  logic [DataWidth-1:0] out_val_q, out_val_d;
  status_e              out_st_q, out_st_d;

  iter_cmd_t            cmd;
  logic [DataWidth-1:0] ix, iy, it_hi, it_lo;
  logic                 it_done;

  logic [DataWidth-1:0] fast_val;
  status_e              fast_st;

  logic                 sa, sb, sq;
  logic [DataWidth-1:0] mag_a, mag_b, mag_acc, mag_base;
  logic                 prod_ovf;
  logic [DataWidth-1:0] prod_val;
  logic [DataWidth-1:0] q_val, r_val, d_val, fin_val;
  logic                 q_ovf;
  status_e              fin_st;
  logic                 s_acc, m_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  assign sa       = a_q[DataWidth-1];
  assign sb       = b_q[DataWidth-1];
  assign sq       = sa ^ sb;
  assign mag_a    = sa ? -a_q : a_q;
  assign mag_b    = sb ? -b_q : b_q;
  assign mag_acc  = acc_q[DataWidth-1] ? -acc_q : acc_q;
  assign mag_base = base_q[DataWidth-1] ? -base_q : base_q;

  cialu_fast #(.DataWidth(DataWidth)) u_fast (
    .op_i  (op_q),
    .a_i   (a_q),
    .b_i   (b_q),
    .val_o (fast_val),
    .st_o  (fast_st)
  );

  cialu_iter #(.DataWidth(DataWidth)) u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .x_i    (ix),
    .y_i    (iy),
    .done_o (it_done),
    .hi_o   (it_hi),
    .lo_o   (it_lo)
  );

  // product check
  assign prod_ovf = (it_hi != '0) ||
                    (mneg_q ? (it_lo > MinV) : it_lo[DataWidth-1]);
  assign prod_val = mneg_q ? -it_lo : it_lo;

  // quotient and remainder fixup
  assign q_ovf = !sq && it_lo[DataWidth-1];
  assign d_val = mag_b - it_hi;
  always_comb begin
    q_val = sq ? -it_lo : it_lo;
    if (op_q == OP_FDIV && sq && it_hi != '0) q_val = ~it_lo;
    r_val = sa ? -it_hi : it_hi;
    if (op_q == OP_MOD && it_hi != '0 && sq) r_val = sb ? -d_val : d_val;
  end

  always_comb begin
    fin_val = '0;
    fin_st  = ST_OK;
    unique case (op_q)
      OP_MUL: if (prod_ovf) fin_st = ST_OVF;
              else fin_val = prod_val;
      OP_TDIV, OP_FDIV: if (q_ovf) fin_st = ST_OVF;
                        else fin_val = q_val;
      OP_MOD, OP_REM: fin_val = r_val;
      OP_EXACTDIV: if (q_ovf || it_hi != '0) fin_st = ST_FLOAT;
                   else fin_val = q_val;
      OP_GCD: if (it_lo[DataWidth-1]) fin_st = ST_OVF;
              else fin_val = it_lo;
      OP_MSB: fin_val = it_lo;
      default: fin_st = ST_UNDEF;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    base_d      = base_q;
    acc_d       = acc_q;
    e_d         = e_q;
    mneg_d      = mneg_q;
    out_valid_d = out_valid_q && !m_acc;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    cmd         = '{start: 1'b0, kind: K_MUL};
    ix          = mag_a;
    iy          = mag_b;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          op_d    = action_e'(s_axis_tdata[ActionW-1:0]);
          a_d     = s_axis_tdata[ActionW +: DataWidth];
          b_d     = s_axis_tdata[ActionW + FieldW +: DataWidth];
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_IDLE;
        unique case (op_q)
          OP_MUL: begin
            cmd     = '{start: 1'b1, kind: K_MUL};
            mneg_d  = sq;
            state_d = S_ITER;
          end
          OP_TDIV, OP_FDIV, OP_MOD, OP_REM, OP_EXACTDIV: begin
            if (b_q != '0) begin
              cmd     = '{start: 1'b1, kind: K_DIV};
              state_d = S_ITER;
            end
          end
          OP_GCD: begin
            cmd     = '{start: 1'b1, kind: K_GCD};
            state_d = S_ITER;
          end
          OP_MSB: begin
            if (!sa && a_q != '0) begin
              cmd     = '{start: 1'b1, kind: K_MSB};
              ix      = a_q;
              state_d = S_ITER;
            end
          end
          OP_POW, OP_ISOPOW: begin
            if (!sb) begin
              base_d  = a_q;
              acc_d   = One;
              e_d     = b_q;
              state_d = S_PTEST;
            end
          end
          default: ;
        endcase
        if (state_d == S_IDLE) begin
          out_valid_d = 1'b1;
          out_val_d   = fast_val;
          out_st_d    = fast_st;
        end
      end
      S_ITER: begin
        if (it_done) begin
          out_valid_d = 1'b1;
          out_val_d   = (fin_st == ST_OK) ? fin_val : '0;
          out_st_d    = fin_st;
          state_d     = S_IDLE;
        end
      end
      S_PTEST: begin
        priority if (e_q == '0) begin
          out_valid_d = 1'b1;
          out_val_d   = acc_q;
          out_st_d    = ST_OK;
          state_d     = S_IDLE;
        end else if (e_q[0]) begin
          cmd     = '{start: 1'b1, kind: K_MUL};
          ix      = mag_acc;
          iy      = mag_base;
          mneg_d  = acc_q[DataWidth-1] ^ base_q[DataWidth-1];
          state_d = S_PACC;
        end else begin
          state_d = S_PSHIFT;
        end
      end
      S_PACC: begin
        if (it_done) begin
          if (prod_ovf) begin
            out_valid_d = 1'b1;
            out_val_d   = '0;
            out_st_d    = ST_OVF;
            state_d     = S_IDLE;
          end else begin
            acc_d   = prod_val;
            state_d = S_PSHIFT;
          end
        end
      end
      S_PSHIFT: begin
        e_d = e_q >> 1;
        if ((e_q >> 1) != '0) begin
          cmd     = '{start: 1'b1, kind: K_MUL};
          ix      = mag_base;
          iy      = mag_base;
          mneg_d  = 1'b0;
          state_d = S_PSQR;
        end else begin
          state_d = S_PTEST;
        end
      end
      S_PSQR: begin
        if (it_done) begin
          if (prod_ovf) begin
            out_valid_d = 1'b1;
            out_val_d   = '0;
            out_st_d    = ST_OVF;
            state_d     = S_IDLE;
          end else begin
            base_d  = prod_val;
            state_d = S_PTEST;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    a_q       <= a_d;
    b_q       <= b_d;
    base_q    <= base_d;
    acc_q     <= acc_d;
    e_q       <= e_d;
    mneg_q    <= mneg_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'({out_st_q, FieldW'($signed(out_val_q))});

  a_ready_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("ready while a result waits");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready && !m_axis_tvalid)
    else $error("request not held busy");

  a_error_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_st_q != ST_OK) |-> (out_val_q == '0))
    else $error("error status with nonzero value");

  a_iter_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> (state_q == S_DISP || state_q == S_PTEST || state_q == S_PSHIFT))
    else $error("iterative unit started from wrong state");

endmodule

`default_nettype wire
